// File: rtl/core/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg: shared definitions for the simple cycle counter
// Field widths, register indexes, item modes, sequencer states and the
// status bundle passed from the search sequencer to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

  localparam int DEFAULT_MAX_VERTICES = 16;

  localparam int MODE_W      = 1;
  localparam int ROW_INDEX_W = 4;
  localparam int ROW_W       = 16;
  localparam int COUNT_W     = 36;
  localparam int FOUND_W     = 37;
  localparam int CFG_FIELD_W = 5;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_COUNT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_CYCLE_LENGTH = CFG_INDEX_W'(1);

  localparam logic [CFG_FIELD_W-1:0] VERTEX_COUNT_RESET = CFG_FIELD_W'(16);
  localparam logic [CFG_FIELD_W-1:0] CYCLE_LENGTH_RESET = CFG_FIELD_W'(3);

  localparam logic [MODE_W-1:0] MODE_LOAD  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_COUNT = 1'b1;

  localparam int MIN_CYCLE_LENGTH = 3;
  localparam int MIN_VERTEX_COUNT = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_POP,
    ST_DONE
  } scc_state_t;

  typedef struct packed {
    logic idle;
    logic done;
  } scc_status_t;

endpackage

`default_nettype wire

// File: rtl/core/scc_ifs.sv
// ----------------------------------------------------------------------------
// scc_ifs: channel interfaces of the simple cycle counter
// Input item, result and configuration write channels, valid/ready each.
// ----------------------------------------------------------------------------
`default_nettype none

interface scc_item_if;
  logic                            valid;
  logic                            ready;
  logic [scc_pkg::MODE_W-1:0]      mode;
  logic [scc_pkg::ROW_INDEX_W-1:0] row_index;
  logic [scc_pkg::ROW_W-1:0]       row_bits;

  modport source (output valid, output mode, output row_index, output row_bits,
                  input ready);
  modport sink (input valid, input mode, input row_index, input row_bits,
                output ready);
endinterface

interface scc_result_if;
  logic                        valid;
  logic                        ready;
  logic [scc_pkg::COUNT_W-1:0] cycle_count;

  modport source (output valid, output cycle_count, input ready);
  modport sink (input valid, input cycle_count, output ready);
endinterface

interface scc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [scc_pkg::CFG_INDEX_W-1:0] index;
  logic [scc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/scc_ram.sv
// ----------------------------------------------------------------------------
// scc_ram: generic single-port-write, single-port-read ram
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/scc_search.sv
// ----------------------------------------------------------------------------
// scc_search: depth-first search sequencer
// Walks one candidate neighbor per cycle while scanning, under a small state
// machine, with path stack and adjacency rows in rams; counts closed paths.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_search #(
  parameter int MAX_VERTICES = scc_pkg::DEFAULT_MAX_VERTICES
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 go,
  input  wire logic [scc_pkg::CFG_FIELD_W-1:0]      vertex_count,
  input  wire logic [scc_pkg::CFG_FIELD_W-1:0]      cycle_length,
  input  wire logic                                 out_free,
  output scc_pkg::scc_status_t                      status,
  output logic      [scc_pkg::FOUND_W-1:0]          found,
  output logic                                      adj_re,
  output logic      [$clog2(MAX_VERTICES)-1:0]      adj_raddr,
  input  wire logic [MAX_VERTICES-1:0]              adj_rdata,
  output logic                                      stk_we,
  output logic      [$clog2(MAX_VERTICES)-1:0]      stk_waddr,
  output logic      [$clog2(MAX_VERTICES)-1:0]      stk_wdata,
  output logic                                      stk_re,
  output logic      [$clog2(MAX_VERTICES)-1:0]      stk_raddr,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]      stk_rdata
);

  import scc_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);

  scc_state_t state, state_next;

  logic [VW-1:0]           d;
  logic [VW-1:0]           v;
  logic [VW-1:0]           s;
  logic [NW-1:0]           j;
  logic [MAX_VERTICES-1:0] visited;
  logic [NW-1:0]           nv;
  logic [VW-1:0]           last_d;
  logic [VW-1:0]           s_last;

  logic          cfg_empty;
  logic [NW-1:0] nv_cfg;
  logic [VW-1:0] last_cfg;
  logic [VW-1:0] slast_cfg;

  logic [VW-1:0] j_idx;
  logic          at_leaf;
  logic          j_in;
  logic          push;
  logic          pop;
  logic          leaf_hit;
  logic          root_pop;
  logic          last_start;

  // search bounds from the configuration registers
  always_comb begin
    int nv_i;
    int len_i;
    nv_i = int'(vertex_count);
    if (nv_i > MAX_VERTICES) begin
      nv_i = MAX_VERTICES;
    end
    len_i = int'(cycle_length);
    cfg_empty = (len_i < MIN_CYCLE_LENGTH) || (nv_i < MIN_VERTEX_COUNT) ||
                (len_i > nv_i - 1);
    nv_cfg    = NW'(nv_i);
    last_cfg  = VW'(len_i - 1);
    slast_cfg = VW'(nv_i - len_i);
  end

  assign j_idx      = j[VW-1:0];
  assign at_leaf    = (d == last_d);
  assign j_in       = (j < nv);
  assign push       = (state == ST_SCAN) && !at_leaf && j_in &&
                      !visited[j_idx] && adj_rdata[j_idx];
  assign pop        = (state == ST_SCAN) && (at_leaf || !j_in);
  assign leaf_hit   = (state == ST_SCAN) && at_leaf && adj_rdata[s];
  assign root_pop   = pop && (d == '0);
  assign last_start = (s == s_last);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (go) begin
          state_next = cfg_empty ? ST_DONE : ST_START;
        end
      end
      ST_START: state_next = ST_SCAN;
      ST_SCAN: begin
        if (root_pop) begin
          state_next = last_start ? ST_DONE : ST_START;
        end else if (pop) begin
          state_next = ST_POP;
        end
      end
      ST_POP: state_next = ST_SCAN;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    status.idle = (state == ST_IDLE);
    status.done = (state == ST_DONE) && out_free;
    adj_re      = 1'b0;
    adj_raddr   = s;
    stk_we      = 1'b0;
    stk_waddr   = d;
    stk_wdata   = s;
    stk_re      = 1'b0;
    stk_raddr   = VW'(d - 1'b1);
    case (state)
      ST_START: begin
        adj_re    = 1'b1;
        adj_raddr = s;
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = s;
      end
      ST_SCAN: begin
        if (push) begin
          adj_re    = 1'b1;
          adj_raddr = j_idx;
          stk_we    = 1'b1;
          stk_waddr = VW'(d + 1'b1);
          stk_wdata = j_idx;
        end else if (pop && !root_pop) begin
          stk_re = 1'b1;
        end
      end
      ST_POP: begin
        adj_re    = 1'b1;
        adj_raddr = stk_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      visited <= '0;
      found   <= '0;
      s       <= '0;
      d       <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (go) begin
            found   <= '0;
            visited <= '0;
            s       <= VW'(1);
          end
        end
        ST_START: begin
          visited[s] <= 1'b1;
          d          <= '0;
        end
        ST_SCAN: begin
          if (leaf_hit) begin
            found <= found + FOUND_W'(1);
          end
          if (push) begin
            visited[j_idx] <= 1'b1;
            d              <= VW'(d + 1'b1);
          end else if (root_pop) begin
            // start stays marked: it is retired for later searches
            s <= VW'(s + 1'b1);
          end else if (pop) begin
            visited[v] <= 1'b0;
            d          <= VW'(d - 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload-like datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (go) begin
          nv     <= nv_cfg;
          last_d <= last_cfg;
          s_last <= slast_cfg;
        end
      end
      ST_START: begin
        v <= s;
        j <= NW'(1);
      end
      ST_SCAN: begin
        if (push) begin
          v <= j_idx;
          j <= NW'(1);
        end else if (pop) begin
          // parent resumes just past the vertex being left
          j <= NW'(NW'(v) + NW'(1));
        end else begin
          j <= NW'(j + 1'b1);
        end
      end
      ST_POP: begin
        v <= stk_rdata;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (d <= last_d))
    else $error("search depth past the cycle length");

  a_start_marked: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> visited[s])
    else $error("start vertex not marked during its search");

  a_cand_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (j <= nv))
    else $error("neighbor candidate beyond vertex count");

  a_push_depth: assert property (@(posedge clk) disable iff (rst)
    push |=> (d == VW'($past(d) + 1'b1)) && visited[v])
    else $error("push did not advance depth and mark vertex");

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |=> $stable(found))
    else $error("count changed after search end");
`endif

endmodule

`default_nettype wire

// File: rtl/core/simple_cycle_counter.sv
// ----------------------------------------------------------------------------
// simple_cycle_counter: counts simple cycles of a set length in a graph
// Loads adjacency rows, then runs a ram-backed depth-first search on demand.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: mode load writes row_bits into row row_index;
//     mode count starts a search over vertices 1 .. vertex_count-1.
//   result channel: one transaction per count item carrying cycle_count,
//     none for a load item.
//   cfg channel: always ready; index 0 is vertex_count, index 1 is
//     cycle_length. Write only while no count is in flight.
// Throughput:
//   loads stream back to back.
//   a count runs a start step per start vertex, a scan per neighbor candidate
//   examined, a scan that ends a vertex and a stack read per step back up the
//   path, a scan to finish each start vertex, plus a done step to leave the
//   search; the search sequencer is the only worker and holds item ready low
//   while busy.
//   an empty configuration goes straight to the done step. The result is
//   registered in the output register as the search leaves its done step.
// Reset: vertex_count 16, cycle_length 3, sequencer idle, result empty.
//   Adjacency rows are undefined until loaded.
// Stall: a pending result leaves loads and a new count start unaffected; a
//   finished count waits in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module simple_cycle_counter #(
  parameter int MAX_VERTICES = scc_pkg::DEFAULT_MAX_VERTICES
) (
  input wire logic      clk,
  input wire logic      rst,
  scc_cfg_if.sink       cfg,
  scc_item_if.sink      item,
  scc_result_if.source  result
);

  import scc_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);

  logic [CFG_FIELD_W-1:0] vertex_count;
  logic [CFG_FIELD_W-1:0] cycle_length;

  scc_status_t        status;
  logic [FOUND_W-1:0] found;
  logic               out_free;
  logic               go;
  logic               item_acc;

  logic                    adj_we;
  logic [VW-1:0]           adj_waddr;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic                    adj_re;
  logic [VW-1:0]           adj_raddr;
  logic [MAX_VERTICES-1:0] adj_rdata;

  logic          stk_we;
  logic [VW-1:0] stk_waddr;
  logic [VW-1:0] stk_wdata;
  logic          stk_re;
  logic [VW-1:0] stk_raddr;
  logic [VW-1:0] stk_rdata;

  logic               res_valid;
  logic [COUNT_W-1:0] res_count;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RESET;
      cycle_length <= CYCLE_LENGTH_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_VERTEX_COUNT: vertex_count <= cfg.data[CFG_FIELD_W-1:0];
        REG_CYCLE_LENGTH: cycle_length <= cfg.data[CFG_FIELD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign item.ready = status.idle;
  assign item_acc   = item.valid && item.ready;
  assign go         = item_acc && (item.mode == MODE_COUNT);

  // rows outside the matrix are dropped
  assign adj_we    = item_acc && (item.mode == MODE_LOAD) &&
                     (int'(item.row_index) < MAX_VERTICES);
  assign adj_waddr = VW'(item.row_index);
  assign adj_wdata = MAX_VERTICES'(item.row_bits);

  scc_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  scc_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_VERTICES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  scc_search #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_search (
    .clk          (clk),
    .rst          (rst),
    .go           (go),
    .vertex_count (vertex_count),
    .cycle_length (cycle_length),
    .out_free     (out_free),
    .status       (status),
    .found        (found),
    .adj_re       (adj_re),
    .adj_raddr    (adj_raddr),
    .adj_rdata    (adj_rdata),
    .stk_we       (stk_we),
    .stk_waddr    (stk_waddr),
    .stk_wdata    (stk_wdata),
    .stk_re       (stk_re),
    .stk_raddr    (stk_raddr),
    .stk_rdata    (stk_rdata)
  );

  assign out_free = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (status.done) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // each cycle is seen in both directions, so halve the total
  always_ff @(posedge clk) begin
    if (status.done) begin
      res_count <= found[FOUND_W-1:1];
    end
  end

  assign result.valid       = res_valid;
  assign result.cycle_count = res_count;

endmodule

`default_nettype wire
